// ===== rtl/cfb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfb_pkg: shared types and constants of the command frame builder
// frame layout, queue sizing and the crc-16/ccitt-false byte update
// ----------------------------------------------------------------------------
package cfb_pkg;

	// frame layout
	localparam int unsigned FRAME_LEN = 10;
	localparam int unsigned POS_W     = $clog2(FRAME_LEN);

	localparam logic [POS_W-1:0] POS_HDR_LAST = POS_W'(3);
	localparam logic [POS_W-1:0] POS_TIME_HI  = POS_W'(4);
	localparam logic [POS_W-1:0] POS_TIME_LO  = POS_W'(5);
	localparam logic [POS_W-1:0] POS_LEVEL_HI = POS_W'(6);
	localparam logic [POS_W-1:0] POS_LEVEL_LO = POS_W'(7);
	localparam logic [POS_W-1:0] POS_CRC_HI   = POS_W'(8);
	localparam logic [POS_W-1:0] POS_CRC_LO   = POS_W'(FRAME_LEN - 1);
	localparam logic [POS_W-1:0] POS_CRC_FIRST = POS_W'(1);

	localparam logic [7:0] HEADER [4] = '{8'hB2, 8'h01, 8'hA5, 8'h04};

	// command codes
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STOP  = 1'b1;

	// crc-16/ccitt-false
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	// command queue
	localparam int unsigned QDEPTH  = 2;
	localparam int unsigned QPTR_W  = $clog2(QDEPTH);
	localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [15:0] test_time;
		logic [15:0] test_level;
	} cfb_item_t;

	// queue to serializer handshake
	typedef struct packed {
		logic valid;
	} cfb_q_status_t;

	typedef struct packed {
		logic pop;
	} cfb_q_ctrl_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] c;
		c = crc ^ {data, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/cfb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfb_front: command intake and queue
// takes command transfers, zeroes the fields of a stop command and holds
// them in a short queue for the serializer
// ----------------------------------------------------------------------------
module cfb_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 cmd,
	input  logic [15:0]          test_time,
	input  logic [15:0]          test_level,
	output cfb_pkg::cfb_item_t   head,
	output cfb_pkg::cfb_q_status_t status,
	input  cfb_pkg::cfb_q_ctrl_t ctrl
);

	cfb_pkg::cfb_item_t           mem_q [cfb_pkg::QDEPTH];
	logic [cfb_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [cfb_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [cfb_pkg::QCNT_W-1:0]   count_q;
	cfb_pkg::cfb_item_t           item;
	logic                         push;
	logic                         pop;

	// stop frames carry zero time and data
	always_comb begin
		if (cmd == cfb_pkg::CMD_STOP) begin
			item = '0;
		end else begin
			item.test_time  = test_time;
			item.test_level = test_level;
		end
	end

	assign in_stall     = (count_q == cfb_pkg::QCNT_W'(cfb_pkg::QDEPTH));
	assign push         = in_valid && !in_stall;
	assign pop          = ctrl.pop && (count_q != '0);
	assign status.valid = (count_q != '0);
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= cfb_pkg::QPTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= cfb_pkg::QPTR_W'(rd_ptr_q + 1'b1);
			end
			case ({push, pop})
				2'b10:   count_q <= cfb_pkg::QCNT_W'(count_q + 1'b1);
				2'b01:   count_q <= cfb_pkg::QCNT_W'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/cfb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfb_back: frame serializer
// walks the ten frame bytes of the queue head, one per output transfer,
// and folds bytes one to seven into the running crc
// ----------------------------------------------------------------------------
module cfb_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfb_pkg::cfb_item_t     head,
	input  cfb_pkg::cfb_q_status_t status,
	output cfb_pkg::cfb_q_ctrl_t   ctrl,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [7:0]             tx_byte,
	output logic                   frame_end
);

	logic [cfb_pkg::POS_W-1:0] pos_q;
	logic [15:0]               crc_q;
	logic                      xfer;
	logic                      last;
	logic                      in_crc;

	assign out_valid = status.valid;
	assign xfer      = out_valid && !out_stall;
	assign last      = (pos_q == cfb_pkg::POS_CRC_LO);
	assign frame_end = last;
	assign ctrl.pop  = xfer && last;
	assign in_crc    = (pos_q >= cfb_pkg::POS_CRC_FIRST) && (pos_q <= cfb_pkg::POS_LEVEL_LO);

	always_comb begin
		unique case (pos_q)
			cfb_pkg::POS_TIME_HI:  tx_byte = head.test_time[15:8];
			cfb_pkg::POS_TIME_LO:  tx_byte = head.test_time[7:0];
			cfb_pkg::POS_LEVEL_HI: tx_byte = head.test_level[15:8];
			cfb_pkg::POS_LEVEL_LO: tx_byte = head.test_level[7:0];
			cfb_pkg::POS_CRC_HI:   tx_byte = crc_q[15:8];
			cfb_pkg::POS_CRC_LO:   tx_byte = crc_q[7:0];
			default: begin
				if (pos_q <= cfb_pkg::POS_HDR_LAST) begin
					tx_byte = cfb_pkg::HEADER[pos_q[1:0]];
				end else begin
					tx_byte = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= cfb_pkg::CRC_INIT;
		end else if (xfer) begin
			if (last) begin
				pos_q <= '0;
				crc_q <= cfb_pkg::CRC_INIT;
			end else begin
				pos_q <= cfb_pkg::POS_W'(pos_q + 1'b1);
				if (in_crc) begin
					crc_q <= cfb_pkg::crc_feed(crc_q, tx_byte);
				end
			end
		end
	end

	// frame position never runs past the crc low byte
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= cfb_pkg::POS_CRC_LO)
		else $error("frame position out of range");

	// closing a frame restarts position and crc for the next one
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && last |=> pos_q == '0 && crc_q == cfb_pkg::CRC_INIT)
		else $error("frame did not restart cleanly");

	// a stalled byte keeps the serializer state
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(pos_q) && $stable(crc_q))
		else $error("serializer moved while stalled");

	// the first byte of a frame is taken with the crc at its initial value
	a_crc_start: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q == '0 |-> crc_q == cfb_pkg::CRC_INIT)
		else $error("crc not initial at frame start");

endmodule

// ===== rtl/command_frame_builder_crc16.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_frame_builder_crc16: command to serial frame builder
// turns one start/stop command into a ten-byte frame with crc-16/ccitt-false
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall): one transfer per command; cmd selects
//   start (time and level sent) or stop (time and level sent as zero)
//   output channel (out_valid / out_stall): ten byte transfers per command,
//   B2 01 A5 04, time hi/lo, level hi/lo, crc hi/lo; frame_end marks the crc
//   low byte
//   first byte: a command is written into the queue; with the queue empty,
//   its first byte is offered in the next cycle, the crc built as bytes go out
//   throughput: the byte-wide output gives one frame byte per cycle while
//   out_stall is low; a two-entry command queue in front of
//   the serializer takes the next command while a frame is still going out
//   receiver stall: the offered byte and the serializer state hold; once the
//   queue is full, in_stall rises
//   reset: arst_n clears the queue and the serializer; nothing is offered
//   until a command arrives
// ----------------------------------------------------------------------------
module command_frame_builder_crc16 (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [15:0] test_time,
	input  logic [15:0] test_level,
	// byte channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  tx_byte,
	output logic        frame_end
);

	// head of the command queue and its handshake with the serializer
	cfb_pkg::cfb_item_t     head;
	cfb_pkg::cfb_q_status_t status;
	cfb_pkg::cfb_q_ctrl_t   ctrl;

	// front: intake, stop-command zeroing, queue
	cfb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.test_time  (test_time),
		.test_level (test_level),
		.head       (head),
		.status     (status),
		.ctrl       (ctrl)
	);

	// back: byte serializer with running crc; pops the queue on the last
	// byte transfer of a frame
	cfb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.status    (status),
		.ctrl      (ctrl),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.tx_byte   (tx_byte),
		.frame_end (frame_end)
	);

endmodule
